// ===== src/rpg_pkg.sv =====
// Package with the shared widths of the resample period block.
package rpg_pkg;

    localparam int SIZE_W      = 16;
    localparam int IN_TDATA_W  = ((2 * SIZE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SIZE_W + 7) / 8) * 8;
    localparam int CNT_W       = $clog2(SIZE_W + 1);
    localparam int TWOS_W      = $clog2(SIZE_W);

    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        logic  start;
        size_t num;
        size_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        size_t quo;
        size_t rem;
    } div_rsp_t;

endpackage

// ===== src/rpg_div.sv =====
// Radix-2 restoring divider that retires one quotient bit per cycle.
module rpg_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  rpg_pkg::div_req_t req,
    output rpg_pkg::div_rsp_t rsp
);
    import rpg_pkg::*;

    size_t             rem_reg, rem_next;
    size_t             quo_reg, quo_next;
    size_t             den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[SIZE_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = CNT_W'(SIZE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            quo_next = {quo_reg[SIZE_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== src/resample_period_gcd.sv =====
// Top level: repeat period of a resampling phase pattern via binary gcd.
//
// Each request carries a source and a destination size; the result is
// dest_size / gcd(source_size mod dest_size, dest_size), or 0 with the
// invalid flag when dest_size is zero. One request is worked on at a time.
// The remainder and the final quotient each come from a shared
// one-bit-per-cycle divider; the binary gcd between them strips one factor
// of two per cycle and does one subtraction per cycle. When the remainder
// is zero the gcd steps are skipped, and a zero destination skips the
// divider. A result held in the output register does not block the next
// request; the following result waits until it drains.
module resample_period_gcd (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rpg_pkg::IN_TDATA_W-1:0]     s_tdata,  // source_size, dest_size
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rpg_pkg::OUT_TDATA_W-1:0]    m_tdata,  // repeat_period
    output logic                               m_tuser   // invalid
);
    import rpg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD, ST_TWOS, ST_ODDA, ST_ODDB, ST_SUB,
        ST_SHIFT, ST_DIV, ST_OUT
    } state_t;

    state_t            state_reg;
    size_t             dst_reg;
    size_t             a_reg;
    size_t             b_reg;
    logic [TWOS_W-1:0] twos_reg;
    size_t             res_reg;
    logic              inv_reg;
    size_t             out_data_reg;
    logic              out_inv_reg;
    logic              m_tvalid_reg;
    div_req_t          div_req_reg;
    div_rsp_t          div_rsp;

    size_t             s_src;
    size_t             s_dst;
    logic [SIZE_W:0]   b_minus_a;
    size_t             a_minus_b;
    logic              a_gt_b;

    assign s_src = s_tdata[SIZE_W-1:0];
    assign s_dst = s_tdata[2*SIZE_W-1:SIZE_W];

    assign b_minus_a = {1'b0, b_reg} - {1'b0, a_reg};
    assign a_minus_b = a_reg - b_reg;
    assign a_gt_b    = b_minus_a[SIZE_W];

    rpg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            div_req_reg.start <= 1'b0;
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        dst_reg <= s_dst;
                        if (s_dst == '0) begin
                            res_reg   <= '0;
                            inv_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            div_req_reg.start <= 1'b1;
                            div_req_reg.num   <= s_src;
                            div_req_reg.den   <= s_dst;
                            state_reg         <= ST_MOD;
                        end
                    end
                end
                ST_MOD: begin
                    if (div_rsp.done) begin
                        twos_reg <= '0;
                        b_reg    <= dst_reg;
                        if (div_rsp.rem == '0) begin
                            a_reg     <= dst_reg;
                            state_reg <= ST_SHIFT;
                        end else begin
                            a_reg     <= div_rsp.rem;
                            state_reg <= ST_TWOS;
                        end
                    end
                end
                ST_TWOS: begin
                    if (!(a_reg[0] | b_reg[0])) begin
                        a_reg    <= a_reg >> 1;
                        b_reg    <= b_reg >> 1;
                        twos_reg <= twos_reg + TWOS_W'(1);
                    end else begin
                        state_reg <= ST_ODDA;
                    end
                end
                ST_ODDA: begin
                    if (!a_reg[0]) begin
                        a_reg <= a_reg >> 1;
                    end else begin
                        state_reg <= ST_ODDB;
                    end
                end
                ST_ODDB: begin
                    if (!b_reg[0]) begin
                        b_reg <= b_reg >> 1;
                    end else begin
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    if (a_gt_b) begin
                        a_reg     <= b_reg;
                        b_reg     <= a_minus_b;
                        state_reg <= ST_ODDB;
                    end else begin
                        b_reg     <= b_minus_a[SIZE_W-1:0];
                        state_reg <= (b_minus_a[SIZE_W-1:0] == '0) ? ST_SHIFT : ST_ODDB;
                    end
                end
                ST_SHIFT: begin
                    if (twos_reg != '0) begin
                        a_reg    <= a_reg << 1;
                        twos_reg <= twos_reg - TWOS_W'(1);
                    end else begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= dst_reg;
                        div_req_reg.den   <= a_reg;
                        state_reg         <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        res_reg   <= div_rsp.quo;
                        inv_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_data_reg <= res_reg;
                        out_inv_reg  <= inv_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);
    assign m_tuser  = out_inv_reg;

endmodule

// ===== sim/rpg_checker.sv =====
// Checker: predicts the repeat period of each accepted request and compares the results.
module rpg_checker
    import rpg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // source_size, dest_size
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // repeat_period
    input  logic                   m_tuser,   // invalid
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        size_t period;
        logic  invalid;
    } period_rec_t;

    period_rec_t period_q[$];
    int          mismatches = 0;

    function automatic period_rec_t predict_period(size_t src, size_t dst);
        period_rec_t rec;
        size_t       a;
        size_t       b;
        size_t       t;
        rec.invalid = (dst == '0);
        rec.period  = '0;
        if (!rec.invalid) begin
            a = dst;
            b = src % dst;
            while (b != '0) begin
                t = a % b;
                a = b;
                b = t;
            end
            rec.period = dst / a;
        end
        return rec;
    endfunction

    always @(posedge aclk) begin
        period_rec_t got;
        period_rec_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                period_q.push_back(predict_period(s_tdata[SIZE_W-1:0],
                                                  s_tdata[2*SIZE_W-1:SIZE_W]));
            end
            if (m_tvalid && m_tready) begin
                got.period  = m_tdata[SIZE_W-1:0];
                got.invalid = m_tuser;
                if (period_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request pending: period=%0d invalid=%0b",
                                 $realtime, got.period, got.invalid);
                end else begin
                    want = period_q.pop_front();
                    if (got.period !== want.period || got.invalid !== want.invalid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected period=%0d invalid=%0b, got period=%0d invalid=%0b",
                                     $realtime, want.period, want.invalid,
                                     got.period, got.invalid);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= period_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: clock, reset, request stimulus, result stalls, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpg_pkg::*;

    localparam int RANDOM_ITEMS   = 1650;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // source_size, dest_size
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // repeat_period
    logic                   m_tuser;   // invalid

    int fail_count;
    int pending;
    int idle_cycles;
    bit send_idle = 1'b1;

    resample_period_gcd DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rpg_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_request(input size_t src, input size_t dst);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_pair(output size_t src, output size_t dst);
        size_t k;
        case ($urandom_range(0, 9))
            0: begin
                src = size_t'($urandom());
                dst = '0;
            end
            1: begin
                dst = size_t'($urandom_range(1, 255));
                k   = size_t'($urandom_range(0, 255));
                src = dst * k;
            end
            2: begin
                src = size_t'($urandom_range(1, 255) << $urandom_range(0, 8));
                dst = size_t'($urandom_range(1, 255) << $urandom_range(0, 8));
            end
            3: begin
                src = size_t'($urandom_range(0, 64));
                dst = size_t'($urandom_range(1, 64));
            end
            4: begin
                src = size_t'($urandom());
                dst = size_t'(1) << $urandom_range(0, SIZE_W - 1);
            end
            default: begin
                src = size_t'($urandom());
                dst = size_t'($urandom());
            end
        endcase
    endtask

    initial begin
        size_t src;
        size_t dst;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'h0001);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'hFFFF, 16'h0001);
        send_request(16'h0001, 16'hFFFF);
        send_request(16'hFFFE, 16'hFFFF);
        send_request(16'h8000, 16'h8000);
        send_request(16'h8000, 16'h4000);
        send_request(16'h0003, 16'h8000);
        send_request(16'h8000, 16'h0003);
        send_request(16'hAAAA, 16'h5555);
        send_request(16'h5555, 16'hAAAA);
        send_request(16'd1920, 16'd1280);
        send_request(16'd1280, 16'd1920);
        send_request(16'd640,  16'd480);
        send_request(16'd48,   16'd64);
        send_request(16'd12,   16'd18);
        send_request(16'd96,   16'd6);
        send_request(16'd7,    16'd5);
        send_request(16'd65521, 16'd65519);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0)
                send_idle = $urandom_range(0, 1);
            random_pair(src, dst);
            send_request(src, dst);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        int hold;
        int results;
        bit stall_on;
        hold     = 0;
        results  = 0;
        stall_on = 1'b1;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_tvalid && m_tready) begin
                results++;
                if (results % 150 == 0)
                    stall_on = $urandom_range(0, 1);
                if (results == 400 || results == 1200)
                    hold = LONG_HOLD;
                else
                    hold = stall_on ? $urandom_range(0, 4) : 0;
            end else if (!m_tready && hold > 0) begin
                hold--;
            end
            m_tready <= (hold == 0);
            @(posedge aclk);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rpg_pkg.sv
src/rpg_div.sv
src/resample_period_gcd.sv
sim/rpg_checker.sv
sim/tb_top.sv
